// ===== hdl/xcs_pkg.sv =====
package xcs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

    localparam logic [CNT_W-1:0] BLOCK_CNT = CNT_W'(BLOCK_BYTES);

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [7:0] ACK_CODE = 8'h06;
    localparam logic [7:0] NAK_CODE = 8'h15;

    typedef enum logic [1:0] {
        KIND_SOURCE = 2'd0,
        KIND_END    = 2'd1,
        KIND_LINE   = 2'd2,
        KIND_SLOT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_BUSY  = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_ABORT = 2'd2
    } status_t;

    // where the transmitted byte comes from in the back stage
    typedef enum logic [1:0] {
        SRC_FIXED = 2'd0,
        SRC_MEM   = 2'd1,
        SRC_PAD   = 2'd2,
        SRC_SUM   = 2'd3
    } src_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] source_byte;
        logic [7:0] line_byte;
    } in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_taken;
        logic [1:0] status;
        logic [7:0] current_packet;
    } out_t;

    // control word handed from the front stage to the back stage
    typedef struct packed {
        logic       tx_valid;
        src_t       src;
        logic [7:0] fixed_byte;
        logic       clr_sum;
        logic       add_sum;
        logic       data_taken;
        logic [1:0] status;
        logic [7:0] current_packet;
    } stage_t;

endpackage

// ===== hdl/xcs_block_ram.sv =====
module xcs_block_ram
    import xcs_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [BLOCK_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/xcs_ctrl.sv =====
module xcs_ctrl
    import xcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  in_t               item,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output stage_t            stage
);

    typedef enum logic [11:0] {
        PH_WAIT_START = 12'b0000_0000_0001,
        PH_FILL       = 12'b0000_0000_0010,
        PH_HEAD       = 12'b0000_0000_0100,
        PH_DATA       = 12'b0000_0000_1000,
        PH_SUM        = 12'b0000_0001_0000,
        PH_WAIT_REPLY = 12'b0000_0010_0000,
        PH_EOT1       = 12'b0000_0100_0000,
        PH_WAIT_NAK2  = 12'b0000_1000_0000,
        PH_EOT2       = 12'b0001_0000_0000,
        PH_WAIT_ACK   = 12'b0010_0000_0000,
        PH_DONE       = 12'b0100_0000_0000,
        PH_ABORT      = 12'b1000_0000_0000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]       pkt_reg, pkt_next;
    logic             last_reg, last_next;

    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] idx_inc;

    assign fill_inc = fill_reg + CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        pkt_next   = pkt_reg;
        last_next  = last_reg;

        wr_en   = 1'b0;
        wr_addr = fill_reg[ADDR_W-1:0];
        wr_data = item.source_byte;
        rd_en   = 1'b0;
        rd_addr = idx_reg[ADDR_W-1:0];

        stage.tx_valid   = 1'b0;
        stage.src        = SRC_FIXED;
        stage.fixed_byte = 8'h00;
        stage.clr_sum    = 1'b0;
        stage.add_sum    = 1'b0;
        stage.data_taken = 1'b0;

        case (kind_t'(item.kind))
            KIND_SOURCE: begin
                if (phase_reg == PH_FILL && fill_reg < BLOCK_CNT) begin
                    wr_en            = accept;
                    fill_next        = fill_inc;
                    stage.data_taken = 1'b1;
                    if (fill_inc >= BLOCK_CNT) begin
                        phase_next = PH_HEAD;
                        idx_next   = '0;
                    end
                end
            end
            KIND_END: begin
                if (phase_reg == PH_FILL) begin
                    stage.data_taken = 1'b1;
                    last_next        = 1'b1;
                    phase_next       = PH_HEAD;
                    idx_next         = '0;
                end
            end
            KIND_LINE: begin
                case (phase_reg)
                    PH_WAIT_START: begin
                        phase_next = (item.line_byte == NAK_CODE) ? PH_FILL : PH_ABORT;
                        fill_next  = '0;
                    end
                    PH_WAIT_REPLY: begin
                        if (item.line_byte == NAK_CODE) begin
                            phase_next = PH_HEAD;
                            idx_next   = '0;
                        end else if (item.line_byte == ACK_CODE) begin
                            pkt_next = pkt_reg + 8'd1;
                            if (last_reg) begin
                                phase_next = PH_EOT1;
                            end else begin
                                phase_next = PH_FILL;
                                fill_next  = '0;
                                last_next  = 1'b0;
                            end
                        end else begin
                            phase_next = PH_ABORT;
                        end
                    end
                    PH_WAIT_NAK2: begin
                        phase_next = (item.line_byte == NAK_CODE) ? PH_EOT2 : PH_ABORT;
                    end
                    PH_WAIT_ACK: begin
                        phase_next = (item.line_byte == ACK_CODE) ? PH_DONE : PH_ABORT;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // transmit slot
                case (phase_reg)
                    PH_HEAD: begin
                        stage.tx_valid = 1'b1;
                        if (idx_reg == CNT_W'(0)) begin
                            stage.fixed_byte = SOH_CODE;
                            stage.clr_sum    = 1'b1;
                            idx_next         = CNT_W'(1);
                        end else if (idx_reg == CNT_W'(1)) begin
                            stage.fixed_byte = pkt_reg;
                            idx_next         = CNT_W'(2);
                        end else begin
                            stage.fixed_byte = ~pkt_reg;
                            idx_next         = '0;
                            phase_next       = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        // payload byte fetched now, lands in the back stage
                        stage.tx_valid = 1'b1;
                        stage.add_sum  = 1'b1;
                        rd_en          = accept;
                        stage.src      = (idx_reg < fill_reg) ? SRC_MEM : SRC_PAD;
                        idx_next       = idx_inc;
                        if (idx_inc >= BLOCK_CNT) begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        stage.tx_valid = 1'b1;
                        stage.src      = SRC_SUM;
                        phase_next     = PH_WAIT_REPLY;
                    end
                    PH_EOT1: begin
                        stage.tx_valid   = 1'b1;
                        stage.fixed_byte = EOT_CODE;
                        phase_next       = PH_WAIT_NAK2;
                    end
                    PH_EOT2: begin
                        stage.tx_valid   = 1'b1;
                        stage.fixed_byte = EOT_CODE;
                        phase_next       = PH_WAIT_ACK;
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        case (phase_next)
            PH_DONE:  stage.status = STAT_DONE;
            PH_ABORT: stage.status = STAT_ABORT;
            default:  stage.status = STAT_BUSY;
        endcase
        stage.current_packet = pkt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT_START;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pkt_reg   <= 8'd1;
            last_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            pkt_reg   <= pkt_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== hdl/xcs_out.sv =====
module xcs_out
    import xcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  stage_t     stage,
    input  logic [7:0] rd_data,
    input  logic [7:0] pad_byte,
    output logic       in_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data
);

    logic       st_valid_reg;
    stage_t     st_reg;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg;
    out_t       out_reg;

    logic       advance;
    logic [7:0] tx_byte;

    assign advance  = st_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !st_valid_reg || !out_valid_reg || m_ready;

    always_comb begin
        case (st_reg.src)
            SRC_MEM: tx_byte = rd_data;
            SRC_PAD: tx_byte = pad_byte;
            SRC_SUM: tx_byte = sum_reg;
            default: tx_byte = st_reg.fixed_byte;
        endcase

        sum_next = sum_reg;
        if (st_reg.clr_sum) begin
            sum_next = 8'h00;
        end else if (st_reg.add_sum) begin
            sum_next = sum_reg + tx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= 8'h00;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= stage;
        end
        if (advance) begin
            out_reg.tx_valid       <= st_reg.tx_valid;
            out_reg.tx_byte        <= tx_byte;
            out_reg.data_taken     <= st_reg.data_taken;
            out_reg.status         <= st_reg.status;
            out_reg.current_packet <= st_reg.current_packet;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hdl/xmodem_checksum_sender.sv =====
// XMODEM sender with 8-bit checksum, one event word per cycle while s_ready is high.
// s_ channel: one event word (kind, source_byte, line_byte) - a source byte,
//   an end-of-source mark, a byte received from the line, or a transmit slot.
// m_ channel: exactly one result word per event (tx_valid, tx_byte,
//   data_taken, status, current_packet), in event order.
// cfg channel: writes pad_byte; always ready. Write only while idle.
// Path: an accepted event is registered in the RAM stage (with the block RAM
//   read), then in the output register, before its result appears on m_.
// Throughput: 1 word per cycle unless m_ready stalls it. Each event does at
//   most one RAM access (a write while filling, a read while sending
//   payload), so the single port pair of the block RAM sets that figure.
// Reset (aresetn low, synchronous): waits for the first NAK, packet
//   number 1, pad_byte 0. No RAM clearing pass; entries at or above the
//   fill count of the current block are sent as pad_byte, not from RAM.
// Stall: with m_ready low the output register holds; one more word can sit
//   in the RAM stage, after which s_ready drops until m_ready returns.
module xmodem_checksum_sender
    import xcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    stage_t            stage;
    logic [7:0]        pad_reg;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg <= 8'h00;
        end else if (cfg_valid) begin
            pad_reg <= cfg_data;
        end
    end

    // front stage: protocol state and RAM access; a write and a later read
    // of the same entry are always on different accept edges
    xcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .stage   (stage)
    );

    xcs_block_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // back stage: byte select, checksum, output register
    xcs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .stage    (stage),
        .rd_data  (rd_data),
        .pad_byte (pad_reg),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
